/* design/sce_pkg.sv */
// ----------------------------------------------------------------------------
// sce_pkg
// Shared types and constants of the subset capacity enumerator.
// ----------------------------------------------------------------------------
package sce_pkg;

	localparam int MaxVars = 32;
	localparam int IdxW = 5;
	localparam int CntW = 6;
	localparam int CapW = 40;
	localparam logic [CapW-1:0] CapMax = {CapW{1'b1}};

	typedef enum logic [1:0] {
		ACT_WR_MATRIX = 2'd0,
		ACT_WR_TARGET = 2'd1,
		ACT_RESTART   = 2'd2,
		ACT_NEXT      = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [IdxW-1:0]    row_index;
		logic [IdxW-1:0]    col_index;
		logic signed [15:0] entry_value;
	} sce_in_t;

	typedef struct packed {
		logic [CapW-1:0]    capacity;
		logic [MaxVars-1:0] subset_mask;
		logic [CntW-1:0]    subset_size;
		logic               final_subset;
		logic               zero_denominator;
		logic               saturated;
	} sce_out_t;

	// Divider request and answer. The row sum needs 21 bits.
	typedef struct packed {
		logic        start;
		logic [39:0] dividend;
		logic [20:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [39:0] quotient;
	} div_rsp_t;

endpackage

/* design/subset_capacity_enumerator_core.sv */
// ----------------------------------------------------------------------------
// subset_capacity_enumerator_core
// Enumerates non-empty subsets by size and computes each integral capacity.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// in        start & !busy          cmd (sce_in_t)
// out       valid, one cycle       result (sce_out_t)
// config    APB write access       variable_count
//
// A store write or restart is carried out as it is accepted. A next request
// steps the subset, scans down for an index to bump and refills the member
// list, then walks each member: row setup, the matrix reads of its row, the
// target check, a pass through the 40-step shared divider and a close. A
// zero row sum skips the divider. Reset clears control state and the member
// list; memories are not cleared. The receiver cannot stall; busy holds off
// new items while one works.
// ----------------------------------------------------------------------------
module subset_capacity_enumerator_core
	import sce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  sce_in_t     cmd,
	output logic        busy,
	output logic        valid,
	output sce_out_t    result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ADV, ST_ADV_FILL, ST_ROW, ST_COL, ST_COL_LAST, ST_TGT,
		ST_DIV_GO, ST_DIV_WAIT, ST_DONE
	} state_t;

	state_t state_q;
	logic [CntW-1:0] varcnt_q;
	logic [IdxW-1:0] memb_q [MaxVars];
	logic [CntW-1:0] size_q;
	logic [CntW-1:0] n_act;
	logic [CntW-1:0] d_q, i_q, p_q;
	logic [20:0]     den_q;
	logic [CapW+3:0] sum_q;
	logic            zden_q;
	logic [MaxVars-1:0] mask_q;
	logic            start_ok;

	// Memory ports.
	logic                 cm_we, tg_we;
	logic [9:0]           cm_raddr;
	logic [15:0]          cm_rdata, tg_rdata;
	logic [IdxW-1:0]      tg_raddr;
	div_req_t             dreq;
	div_rsp_t             drsp;
	logic [15:0]          y_abs_q;
	logic [15:0]          r_abs;

	assign pready = 1'b1;
	assign prdata = {26'd0, varcnt_q};
	assign busy   = (state_q != ST_IDLE);
	assign start_ok = start && !busy;

	// Active variable count, clamped to 1..MaxVars.
	always_comb begin
		if (varcnt_q == '0) begin
			n_act = CntW'(1);
		end else if (varcnt_q > CntW'(MaxVars)) begin
			n_act = CntW'(MaxVars);
		end else begin
			n_act = varcnt_q;
		end
	end

	assign cm_we = start_ok && (cmd.action == ACT_WR_MATRIX);
	assign tg_we = start_ok && (cmd.action == ACT_WR_TARGET);
	assign cm_raddr = {memb_q[d_q[IdxW-1:0]], memb_q[i_q[IdxW-1:0]]};
	assign tg_raddr = memb_q[d_q[IdxW-1:0]];
	assign r_abs = cm_rdata[15] ? 16'(-cm_rdata) : cm_rdata;

	sce_ram #(.Width(16), .Depth(MaxVars * MaxVars)) u_corr (
		.clk(clk), .we(cm_we), .waddr({cmd.row_index, cmd.col_index}),
		.wdata(cmd.entry_value), .raddr(cm_raddr), .rdata(cm_rdata)
	);

	sce_ram #(.Width(16), .Depth(MaxVars)) u_tgt (
		.clk(clk), .we(tg_we), .waddr(cmd.row_index),
		.wdata(cmd.entry_value), .raddr(tg_raddr), .rdata(tg_rdata)
	);

	sce_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// Divider request: (y^2 << 8) / row sum. The row sum fits in 21 bits.
	always_comb begin
		dreq.start    = (state_q == ST_DIV_GO);
		dreq.dividend = {32'(y_abs_q) * 32'(y_abs_q), 8'd0};
		dreq.divisor  = den_q;
	end

	// Sequencer: advance the subset, then walk rows and columns.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			varcnt_q <= CntW'(1);
			size_q   <= '0;
			valid    <= 1'b0;
			for (int j = 0; j < MaxVars; j++) begin
				memb_q[j] <= '0;
			end
		end else begin
			valid <= 1'b0;
			if (psel && penable && pwrite && paddr == 2'd0) begin
				varcnt_q <= pwdata[CntW-1:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start_ok) begin
						if (cmd.action == ACT_RESTART) begin
							size_q <= '0;
						end else if (cmd.action == ACT_NEXT) begin
							state_q <= ST_ADV;
						end
					end
				end
				ST_ADV: begin
					if (size_q == '0 || size_q > n_act ||
					    CntW'(memb_q[size_q[IdxW-1:0] - 5'd1]) >= n_act) begin
						memb_q[0] <= '0;
						size_q    <= CntW'(1);
						state_q   <= ST_ADV_FILL;
						p_q       <= CntW'(MaxVars);
					end else begin
						p_q     <= size_q - CntW'(1);
						state_q <= ST_ADV_FILL;
						i_q     <= '0;
					end
				end
				ST_ADV_FILL: begin
					// Scan down one position a cycle for an index to bump.
					if (p_q == CntW'(MaxVars)) begin
						state_q <= ST_ROW;
					end else if (i_q == '0) begin
						if (CntW'(memb_q[p_q[IdxW-1:0]]) <
						    n_act - size_q + p_q) begin
							memb_q[p_q[IdxW-1:0]] <= memb_q[p_q[IdxW-1:0]] + 5'd1;
							i_q <= p_q + CntW'(1);
						end else if (p_q == '0) begin
							// Next size, or wrap to size one.
							for (int j = 0; j < MaxVars; j++) begin
								memb_q[j] <= IdxW'(j);
							end
							size_q  <= (size_q < n_act) ? size_q + CntW'(1) : CntW'(1);
							state_q <= ST_ROW;
						end else begin
							p_q <= p_q - CntW'(1);
						end
					end else if (i_q < size_q) begin
						memb_q[i_q[IdxW-1:0]] <= memb_q[i_q[IdxW-1:0] - 5'd1] + 5'd1;
						i_q <= i_q + CntW'(1);
					end else begin
						state_q <= ST_ROW;
					end
					if (state_q != ST_ROW) begin
						d_q    <= '0;
						sum_q  <= '0;
						zden_q <= 1'b0;
						mask_q <= '0;
					end
				end
				ST_ROW: begin
					i_q     <= '0;
					den_q   <= '0;
					mask_q  <= mask_q | (MaxVars'(1) << memb_q[d_q[IdxW-1:0]]);
					state_q <= ST_COL;
				end
				ST_COL: begin
					// Read issued for column i_q; data lands next cycle.
					if (i_q != '0) begin
						den_q <= den_q + 21'(r_abs);
					end
					if (i_q == size_q - CntW'(1)) begin
						state_q <= ST_COL_LAST;
					end else begin
						i_q <= i_q + CntW'(1);
					end
				end
				ST_COL_LAST: begin
					den_q   <= den_q + 21'(r_abs);
					state_q <= ST_TGT;
				end
				ST_TGT: begin
					y_abs_q <= tg_rdata[15] ? 16'(-tg_rdata) : tg_rdata;
					if (den_q == '0) begin
						zden_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (drsp.done) begin
						sum_q   <= sum_q + (CapW+4)'(drsp.quotient);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (d_q == size_q - CntW'(1)) begin
						valid <= 1'b1;
						result.capacity <= (zden_q || (|sum_q[CapW+3:CapW])) ? CapMax
						                   : sum_q[CapW-1:0];
						result.subset_mask  <= mask_q;
						result.subset_size  <= size_q;
						result.final_subset <= (size_q == n_act);
						result.zero_denominator <= zden_q;
						result.saturated <= |sum_q[CapW+3:CapW];
						state_q <= ST_IDLE;
					end else begin
						d_q     <= d_q + CntW'(1);
						state_q <= ST_ROW;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* design/sce_ram.sv */
// ----------------------------------------------------------------------------
// sce_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module sce_ram #(
	parameter int Width = 16,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/sce_div.sv */
// ----------------------------------------------------------------------------
// sce_div
// Radix-2 restoring divider: one quotient bit per cycle, 40 quotient bits.
// ----------------------------------------------------------------------------
module sce_div
	import sce_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [39:0] quo_q;
	logic [20:0] dsr_q;
	logic [20:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [21:0] trial;
	logic [22:0] diff;

	// One trial subtraction per cycle.
	always_comb begin
		trial = {rem_q, quo_q[39]};
		diff  = {1'b0, trial} - {2'b00, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd40;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[22]) begin
				rem_q <= diff[20:0];
				quo_q <= {quo_q[38:0], 1'b1};
			end else begin
				rem_q <= trial[20:0];
				quo_q <= {quo_q[38:0], 1'b0};
			end
		end
	end

	assign rsp = {done_q, quo_q};

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the subset capacity enumerator core.
// Commands come from a queue and go out in random bursts. A built-in
// predictor follows the subset order and the capacity arithmetic, and a
// monitor compares every result strobe with the oldest expected result.
// The variable count is changed between phases, only while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import sce_pkg::*;

	localparam int CycleLimit = 4000000;
	localparam int FillVars = 8;

	logic        clk;
	logic        arst_n;
	logic        start;
	sce_in_t     cmd;
	logic        busy;
	logic        valid;
	sce_out_t    result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	subset_capacity_enumerator_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.valid   (valid),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Pending commands, and capacities expected from accepted next requests.
	sce_in_t  pending_cmds[$];
	sce_out_t expected_caps[$];

	// Predictor state.
	logic signed [15:0] corr_m[MaxVars][MaxVars];
	logic signed [15:0] target_v[MaxVars];
	int                 members[MaxVars] = '{default: 0};
	int                 member_cnt = 0;
	int unsigned        var_count = 1;

	int errors = 0;
	int cycles = 0;
	int checked = 0;
	int n_final = 0;
	int n_zero = 0;
	int n_sat = 0;
	int burst_left = 1;
	int gap_left = 0;

	initial begin
		clk = 1'b0;
		forever begin
			#6 clk = 1'b1;
			#6 clk = 1'b0;
		end
	end

	// Update the predicted state for one accepted command.
	task automatic apply_command(input sce_in_t c);
		int n, k, p, j, d, i, y, rv;
		bit moved, zd, sat;
		logic [63:0] acc, ysq;
		logic [31:0] den, mask;
		sce_out_t r;
		case (action_t'(c.action))
			ACT_WR_MATRIX: corr_m[c.row_index][c.col_index] = c.entry_value;
			ACT_WR_TARGET: target_v[c.row_index] = c.entry_value;
			ACT_RESTART:   member_cnt = 0;
			ACT_NEXT: begin
				n = (var_count < 1) ? 1 : ((var_count > MaxVars) ? MaxVars : var_count);
				k = member_cnt;
				// Step to the next subset: by size, then lexicographic.
				if (k == 0 || k > n || members[k-1] >= n) begin
					members[0] = 0;
					member_cnt = 1;
				end else begin
					moved = 0;
					for (p = k - 1; p >= 0 && !moved; p--) begin
						if (members[p] < n - k + p) begin
							members[p]++;
							for (j = p + 1; j < k; j++) members[j] = members[j-1] + 1;
							moved = 1;
						end
					end
					if (!moved) begin
						member_cnt = (k < n) ? k + 1 : 1;
						for (j = 0; j < member_cnt; j++) members[j] = j;
					end
				end
				k = member_cnt;
				acc = '0;
				mask = '0;
				zd = 0;
				sat = 0;
				// Sum of y^2 over the absolute row sum within the subset.
				for (d = 0; d < k; d++) begin
					den = '0;
					y = target_v[members[d]];
					ysq = 64'(y * y);
					mask[members[d]] = 1'b1;
					for (i = 0; i < k; i++) begin
						rv = corr_m[members[d]][members[i]];
						den += 32'((rv < 0) ? -rv : rv);
					end
					if (den == 0) zd = 1;
					else acc += (ysq << 8) / den;
				end
				if (acc > 64'(CapMax)) begin
					acc = 64'(CapMax);
					sat = 1;
				end
				if (zd) acc = 64'(CapMax);
				r.capacity         = acc[CapW-1:0];
				r.subset_mask      = mask;
				r.subset_size      = CntW'(k);
				r.final_subset     = (k == n);
				r.zero_denominator = zd;
				r.saturated        = sat;
				expected_caps.insert(expected_caps.size(), r);
			end
		endcase
	endtask

	// Driver: random bursts and gaps; one item per start & !busy edge.
	always @(posedge clk) begin
		bit go;
		go = 0;
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else begin
			if (start && !busy) begin
				apply_command(cmd);
				void'(pending_cmds.pop_front());
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				end
			end
			if (gap_left > 0) gap_left--;
			else if (pending_cmds.size() > 0) go = 1;
			start <= go;
			if (go) cmd <= pending_cmds[0];
		end
	end

	// Monitor: compare each strobed result with the oldest expectation.
	always @(posedge clk) begin
		sce_out_t e;
		if (arst_n && valid) begin
			if (expected_caps.size() == 0) begin
				$error("result with no expectation: mask %h", result.subset_mask);
				errors++;
			end else begin
				e = expected_caps.pop_front();
				checked++;
				if (e.final_subset) n_final++;
				if (e.zero_denominator) n_zero++;
				if (e.saturated) n_sat++;
				if (result.capacity !== e.capacity) begin
					$error("capacity: expected %h actual %h", e.capacity, result.capacity);
					errors++;
				end
				if (result.subset_mask !== e.subset_mask) begin
					$error("subset_mask: expected %h actual %h", e.subset_mask,
						result.subset_mask);
					errors++;
				end
				if (result.subset_size !== e.subset_size) begin
					$error("subset_size: expected %0d actual %0d", e.subset_size,
						result.subset_size);
					errors++;
				end
				if (result.final_subset !== e.final_subset) begin
					$error("final_subset: expected %b actual %b", e.final_subset,
						result.final_subset);
					errors++;
				end
				if (result.zero_denominator !== e.zero_denominator) begin
					$error("zero_denominator: expected %b actual %b", e.zero_denominator,
						result.zero_denominator);
					errors++;
				end
				if (result.saturated !== e.saturated) begin
					$error("saturated: expected %b actual %b", e.saturated, result.saturated);
					errors++;
				end
			end
		end
	end

	// Run time limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic void push_cmd(action_t a, int r, int c, int v);
		sce_in_t s;
		s.action      = a;
		s.row_index   = IdxW'(r);
		s.col_index   = IdxW'(c);
		s.entry_value = 16'(v);
		pending_cmds.insert(pending_cmds.size(), s);
	endfunction

	// Random value leaning on the extremes and on zero and unit values.
	function automatic int pick_value();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return -1;
			3: return -32768;
			4: return 32767;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// Random command: mostly next requests, indices mostly inside the count.
	function automatic void push_random(int n);
		int sel, r, c;
		if (n < 1) n = 1;
		sel = $urandom_range(0, 99);
		r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n - 1);
		c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n - 1);
		if (sel < 58) push_cmd(ACT_NEXT, $urandom_range(0, 31), $urandom_range(0, 31),
			pick_value());
		else if (sel < 80) push_cmd(ACT_WR_MATRIX, r, c, pick_value());
		else if (sel < 93) push_cmd(ACT_WR_TARGET, r, $urandom_range(0, 31), pick_value());
		else push_cmd(ACT_RESTART, $urandom_range(0, 31), $urandom_range(0, 31),
			pick_value());
	endfunction

	// Wait until all items are taken and all results are back, then settle.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || start || busy || expected_caps.size() != 0);
		repeat (60) @(posedge clk);
	endtask

	// APB write of the variable count (register 0).
	task automatic write_count(input int unsigned v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= '0;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		var_count = v & 32'h3F;
	endtask

	initial begin
		int phase_counts[9] = '{3, 5, 8, 0, 4, 2, 6, 8, 3};
		int phase_items[9]  = '{40, 50, 30, 20, 50, 30, 60, 30, 50};
		int ph, i, j;
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Fill the stores for every variable that any phase uses, so that no
		// later read hits an unwritten entry.
		for (i = 0; i < FillVars; i++) begin
			for (j = 0; j < FillVars; j++) push_cmd(ACT_WR_MATRIX, i, j, pick_value());
			push_cmd(ACT_WR_TARGET, i, 0, pick_value());
		end
		wait_drained();

		// Directed: unit diagonal with full-scale targets saturates large subsets;
		// walk the whole enumeration of five variables, its final set and the wrap.
		write_count(5);
		for (i = 0; i < 5; i++) begin
			for (j = 0; j < 5; j++) push_cmd(ACT_WR_MATRIX, i, j, (i == j) ? 1 : 0);
			push_cmd(ACT_WR_TARGET, i, 31, (i == 2) ? 32767 : -32768);
		end
		push_cmd(ACT_WR_MATRIX, 31, 31, 32767);
		push_cmd(ACT_RESTART, 31, 31, -1);
		for (i = 0; i < 32; i++) push_cmd(ACT_NEXT, i, 31 - i, 0);
		wait_drained();

		// Directed: a zero row sum, then an all-zero row in a larger subset.
		push_cmd(ACT_WR_MATRIX, 4, 4, 0);
		push_cmd(ACT_RESTART, 0, 0, 0);
		for (i = 0; i < 9; i++) push_cmd(ACT_NEXT, 0, 0, 0);
		wait_drained();

		// Random phases over several counts, zero among them; the count shrinks
		// mid-enumeration too.
		for (ph = 0; ph < 9; ph++) begin
			write_count(phase_counts[ph]);
			if ($urandom_range(0, 1)) push_cmd(ACT_RESTART, 0, 0, 0);
			for (i = 0; i < phase_items[ph]; i++) push_random(phase_counts[ph]);
			wait_drained();
		end

		$display("Checked %0d subset results: %0d final sets,", checked, n_final);
		$display("%0d zero denominators and %0d saturated sums.", n_zero, n_sat);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

endmodule
